### rtl/ipv4p_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 header parser package
// Shared record types and protocol constants for the front end, the packet
// record queue and the back end.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

    // Result status codes.
    localparam logic [1:0] C_STATUS_INVALID = 2'd0;
    localparam logic [1:0] C_STATUS_IP      = 2'd1;
    localparam logic [1:0] C_STATUS_UDP     = 2'd2;
    localparam logic [1:0] C_STATUS_TCP     = 2'd3;

    localparam logic [7:0]  C_PROTO_UDP    = 8'd17;
    localparam logic [7:0]  C_PROTO_TCP    = 8'd6;
    localparam logic [3:0]  C_IP_VERSION   = 4'd4;
    localparam logic [15:0] C_IP_MIN_HDR   = 16'd20;
    localparam logic [15:0] C_UDP_HDR      = 16'd8;
    localparam logic [15:0] C_TCP_MIN_HDR  = 16'd20;
    localparam logic [15:0] C_FRAG_MASK    = 16'h3fff;
    localparam logic [15:0] C_COUNT_MAX    = 16'hffff;

    // Everything captured from one packet, handed from front to back.
    typedef struct packed {
        logic [15:0] size;        // bytes captured, saturated
        logic [7:0]  version_ihl;
        logic [15:0] total_len;
        logic [15:0] frag_word;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] udp_len;
        logic [3:0]  tcp_offset;  // data offset in 32-bit words
        logic [3:0]  tcp_flags;   // ack, rst, syn, fin
    } t_rec;

    // One decoded result.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  protocol;
        logic [5:0]  ip_hdr_bytes;
        logic [15:0] total_len;
        logic        fragmented;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [3:0]  tcp_flags;
        logic [15:0] pl_offset;
        logic [15:0] pl_length;
    } t_res;

endpackage

### rtl/ipv4p_front.sv
// ----------------------------------------------------------------------------
// IPv4 header parser front end
// Counts the bytes of a packet, captures header fields as they pass and
// pushes one packet record at the last byte.
// ----------------------------------------------------------------------------
module ipv4p_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last_byte,
    input  logic            i_full,
    output logic            o_rec_push,
    output ipv4p_pkg::t_rec o_rec
);

    logic [15:0] r_count,  n_count;
    logic [7:0]  r_vihl,   n_vihl;
    logic [15:0] r_tl,     n_tl;
    logic [15:0] r_fw,     n_fw;
    logic [7:0]  r_proto,  n_proto;
    logic [31:0] r_src,    n_src;
    logic [31:0] r_dst,    n_dst;
    logic [47:0] r_th,     n_th;
    logic [3:0]  r_off,    n_off;
    logic [3:0]  r_flags,  n_flags;

    logic        w_accept;
    logic [5:0]  w_hl;
    logic [15:0] w_k;

    assign w_accept = i_push && !i_full;

    always_comb begin
        n_vihl  = r_vihl;
        n_tl    = r_tl;
        n_fw    = r_fw;
        n_proto = r_proto;
        n_src   = r_src;
        n_dst   = r_dst;
        n_th    = r_th;
        n_off   = r_off;
        n_flags = r_flags;

        if (r_count == 16'd0) begin
            n_vihl = i_data_byte;
        end
        if (r_count == 16'd2 || r_count == 16'd3) begin
            n_tl = {r_tl[7:0], i_data_byte};
        end
        if (r_count == 16'd6 || r_count == 16'd7) begin
            n_fw = {r_fw[7:0], i_data_byte};
        end
        if (r_count == 16'd9) begin
            n_proto = i_data_byte;
        end
        if (r_count >= 16'd12 && r_count <= 16'd15) begin
            n_src = {r_src[23:0], i_data_byte};
        end
        if (r_count >= 16'd16 && r_count <= 16'd19) begin
            n_dst = {r_dst[23:0], i_data_byte};
        end

        // The header length in effect includes this very byte at position zero.
        w_hl = {n_vihl[3:0], 2'b00};
        w_k  = r_count - {10'd0, w_hl};
        if (r_count >= {10'd0, w_hl}) begin
            if (w_k < 16'd6) begin
                case (w_k[2:0])
                    3'd0:    n_th[47:40] = i_data_byte;
                    3'd1:    n_th[39:32] = i_data_byte;
                    3'd2:    n_th[31:24] = i_data_byte;
                    3'd3:    n_th[23:16] = i_data_byte;
                    3'd4:    n_th[15:8]  = i_data_byte;
                    default: n_th[7:0]   = i_data_byte;
                endcase
            end else if (w_k == 16'd12) begin
                n_off = i_data_byte[7:4];
            end else if (w_k == 16'd13) begin
                n_flags = {i_data_byte[4], i_data_byte[2], i_data_byte[1], i_data_byte[0]};
            end
        end

        n_count = (r_count == ipv4p_pkg::C_COUNT_MAX) ? r_count : r_count + 16'd1;
    end

    always_comb begin
        o_rec_push        = w_accept && i_last_byte;
        o_rec.size        = n_count;
        o_rec.version_ihl = n_vihl;
        o_rec.total_len   = n_tl;
        o_rec.frag_word   = n_fw;
        o_rec.protocol    = n_proto;
        o_rec.src_addr    = n_src;
        o_rec.dst_addr    = n_dst;
        o_rec.sport       = n_th[47:32];
        o_rec.dport       = n_th[31:16];
        o_rec.udp_len     = n_th[15:0];
        o_rec.tcp_offset  = n_off;
        o_rec.tcp_flags   = n_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_last_byte)) begin
            r_count <= '0;
            r_vihl  <= '0;
            r_tl    <= '0;
            r_fw    <= '0;
            r_proto <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_th    <= '0;
            r_off   <= '0;
            r_flags <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
            r_vihl  <= n_vihl;
            r_tl    <= n_tl;
            r_fw    <= n_fw;
            r_proto <= n_proto;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_th    <= n_th;
            r_off   <= n_off;
            r_flags <= n_flags;
        end
    end

endmodule

### rtl/ipv4p_rec_fifo.sv
// ----------------------------------------------------------------------------
// IPv4 header parser record queue
// Short first-in first-out queue of packet records between front and back.
// ----------------------------------------------------------------------------
module ipv4p_rec_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ipv4p_pkg::t_rec i_rec,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output ipv4p_pkg::t_rec o_rec
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ipv4p_pkg::t_rec r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_cnt;
    logic            w_wr;
    logic            w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/ipv4p_back.sv
// ----------------------------------------------------------------------------
// IPv4 header parser back end
// Validates a packet record, decodes UDP or TCP and holds the result in an
// output register until it is taken.
// ----------------------------------------------------------------------------
module ipv4p_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rec_empty,
    input  ipv4p_pkg::t_rec i_rec,
    output logic            o_rec_pop,
    output logic            o_empty,
    input  logic            i_pop,
    output ipv4p_pkg::t_res o_res
);

    logic            r_valid;
    ipv4p_pkg::t_res r_res, n_res;

    logic [15:0] w_hl;
    logic [15:0] w_thl;
    logic [15:0] w_psize;
    logic        w_ip_ok;
    logic        w_frag;

    assign o_rec_pop = !i_rec_empty && (!r_valid || i_pop);
    assign o_empty   = !r_valid;
    assign o_res     = r_res;

    always_comb begin
        w_hl    = {10'd0, i_rec.version_ihl[3:0], 2'b00};
        w_thl   = {10'd0, i_rec.tcp_offset, 2'b00};
        w_psize = i_rec.total_len - w_hl;
        w_frag  = (i_rec.frag_word & ipv4p_pkg::C_FRAG_MASK) != 16'd0;
        w_ip_ok = !(i_rec.size < ipv4p_pkg::C_IP_MIN_HDR
                    || i_rec.version_ihl[7:4] != ipv4p_pkg::C_IP_VERSION
                    || w_hl < ipv4p_pkg::C_IP_MIN_HDR
                    || i_rec.size < w_hl
                    || i_rec.total_len < w_hl
                    || i_rec.size < i_rec.total_len);

        n_res = '0;
        if (w_ip_ok) begin
            n_res.status       = ipv4p_pkg::C_STATUS_IP;
            n_res.src_addr     = i_rec.src_addr;
            n_res.dst_addr     = i_rec.dst_addr;
            n_res.protocol     = i_rec.protocol;
            n_res.ip_hdr_bytes = w_hl[5:0];
            n_res.total_len    = i_rec.total_len;
            n_res.fragmented   = w_frag;
            n_res.pl_offset    = w_hl;
            n_res.pl_length    = w_psize;
            if (!w_frag) begin
                if (i_rec.protocol == ipv4p_pkg::C_PROTO_UDP
                    && w_psize >= ipv4p_pkg::C_UDP_HDR
                    && i_rec.udp_len >= ipv4p_pkg::C_UDP_HDR
                    && i_rec.udp_len <= w_psize) begin
                    n_res.status    = ipv4p_pkg::C_STATUS_UDP;
                    n_res.sport     = i_rec.sport;
                    n_res.dport     = i_rec.dport;
                    n_res.pl_offset = w_hl + ipv4p_pkg::C_UDP_HDR;
                    n_res.pl_length = i_rec.udp_len - ipv4p_pkg::C_UDP_HDR;
                end else if (i_rec.protocol == ipv4p_pkg::C_PROTO_TCP
                    && w_psize >= ipv4p_pkg::C_TCP_MIN_HDR
                    && w_thl >= ipv4p_pkg::C_TCP_MIN_HDR
                    && w_psize >= w_thl) begin
                    n_res.status    = ipv4p_pkg::C_STATUS_TCP;
                    n_res.sport     = i_rec.sport;
                    n_res.dport     = i_rec.dport;
                    n_res.tcp_flags = i_rec.tcp_flags;
                    n_res.pl_offset = w_hl + w_thl;
                    n_res.pl_length = w_psize - w_thl;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rec_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_pop) begin
            r_res <= n_res;
        end
    end

endmodule

### rtl/ipv4_udp_tcp_header_parser.sv
// A record is queued with its last byte; the back end registers its result on pop.
// Throughput: one byte per cycle; one result per cycle can leave the back end.
// Input stalls (full) only when the record queue is full because results wait.
// Reset (i_rst_n low at a clock edge) drops the packet in progress, empties the
// record queue and the output register; the first byte after reset is byte 0.
// ----------------------------------------------------------------------------
// IPv4 / UDP / TCP header parser
// Takes a captured IPv4 packet one byte per transaction, last byte marked, and
// returns one decoded header result per packet.
// ----------------------------------------------------------------------------
module ipv4_udp_tcp_header_parser #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input, queue style.
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // Result output, queue style.
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [31:0] o_source_address,
    output logic [31:0] o_destination_address,
    output logic [7:0]  o_protocol_number,
    output logic [5:0]  o_ip_header_bytes,
    output logic [15:0] o_ip_total_length,
    output logic        o_fragmented,
    output logic [15:0] o_source_port,
    output logic [15:0] o_destination_port,
    output logic [3:0]  o_tcp_flags,
    output logic [15:0] o_payload_offset,
    output logic [15:0] o_payload_length
);

    // The front end runs at byte rate: it tracks the byte position, captures
    // header fields and the first transport bytes, and at the marked byte
    // emits one packet record. The record queue decouples it from the back
    // end, which does all length checks and transport decoding on the record
    // and parks the result in an output register until it is popped.

    logic            w_rec_push;
    ipv4p_pkg::t_rec w_front_rec;
    logic            w_q_full;
    logic            w_q_empty;
    logic            w_q_pop;
    ipv4p_pkg::t_rec w_q_rec;
    ipv4p_pkg::t_res w_res;

    // The input is back-pressured only when a finished packet record cannot be
    // queued; bytes in the middle of a packet would be fine, but holding the
    // whole stream keeps the rule simple for the sender.
    assign full = w_q_full;

    ipv4p_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_full      (w_q_full),
        .o_rec_push  (w_rec_push),
        .o_rec       (w_front_rec)
    );

    ipv4p_rec_fifo #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_rec_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rec_push),
        .i_rec   (w_front_rec),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_rec   (w_q_rec)
    );

    ipv4p_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_empty (w_q_empty),
        .i_rec       (w_q_rec),
        .o_rec_pop   (w_q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (w_res)
    );

    // Result fields; an invalid packet reports zero in every field.
    assign o_status              = w_res.status;
    assign o_source_address      = w_res.src_addr;
    assign o_destination_address = w_res.dst_addr;
    assign o_protocol_number     = w_res.protocol;
    assign o_ip_header_bytes     = w_res.ip_hdr_bytes;
    assign o_ip_total_length     = w_res.total_len;
    assign o_fragmented          = w_res.fragmented;
    assign o_source_port         = w_res.sport;
    assign o_destination_port    = w_res.dport;
    assign o_tcp_flags           = w_res.tcp_flags;
    assign o_payload_offset      = w_res.pl_offset;
    assign o_payload_length      = w_res.pl_length;

endmodule
